/* src/cbd_pkg.sv */
// ============================================================================
// cbd_pkg : chunked body decoder shared definitions
// Phase, fault and status codes, the result bundle and the hex digit decode
// used by the decoder core and the top level.
// ============================================================================
`default_nettype none

package cbd_pkg;

    // Register map (word index taken from paddr[2])
    localparam int unsigned REG_ADDR_W        = 3;
    localparam logic        REG_MAX_CHUNK     = 1'b0;
    localparam logic        REG_OUT_CAPACITY  = 1'b1;
    localparam logic [31:0] MAX_CHUNK_RESET   = 32'd1048576;
    localparam logic [31:0] OUT_CAP_RESET     = 32'd1048576;

    // Characters of the chunk framing
    localparam logic [7:0] CHAR_SEMI = 8'h3B;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;

    // One hex digit is worth a factor of sixteen
    localparam int unsigned HEX_SHIFT = 4;

    typedef enum logic [3:0] {
        PH_SIZE     = 4'd0,
        PH_EXT      = 4'd1,
        PH_SIZE_LF  = 4'd2,
        PH_EXT_LF   = 4'd3,
        PH_DATA     = 4'd4,
        PH_TRAIL_CR = 4'd5,
        PH_TRAIL_LF = 4'd6,
        PH_LAST_CR  = 4'd7,
        PH_LAST_LF  = 4'd8,
        PH_DONE     = 4'd9
    } phase_t;

    typedef enum logic [1:0] {
        FAULT_NONE = 2'd0,
        FAULT_BAD  = 2'd1,
        FAULT_BIG  = 2'd2
    } fault_t;

    typedef enum logic [2:0] {
        ST_BUSY     = 3'd0,
        ST_COMPLETE = 3'd1,
        ST_BAD      = 3'd2,
        ST_TOO_BIG  = 3'd3,
        ST_BEYOND   = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       data_valid;
        status_t    status;
    } result_t;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } hex_digit_t;

    // Decode one ASCII hex digit
    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        d.is_hex = 1'b0;
        d.value  = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d.is_hex = 1'b1;
            d.value  = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d.is_hex = 1'b1;
            d.value  = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d.is_hex = 1'b1;
            d.value  = 4'(c - 8'h37);
        end
        return d;
    endfunction

endpackage

`default_nettype wire

/* src/cbd_core.sv */
// ============================================================================
// cbd_core : chunked body decoder state and per-byte step
// Holds the framing phase, size accumulator and counters, works out the
// result for the offered byte and advances the state when it is accepted.
// ============================================================================
`default_nettype none

module cbd_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            step_en,
    input  wire logic [7:0]      wire_byte,
    input  wire logic            new_body,
    input  wire logic [31:0]     max_chunk_size,
    input  wire logic [31:0]     out_capacity,
    output cbd_pkg::result_t     result
);

    cbd_pkg::phase_t phase_reg,     phase_next;
    cbd_pkg::fault_t fault_reg,     fault_next;
    logic [31:0]     remaining_reg, remaining_next;
    logic [31:0]     acc_reg,       acc_next;
    logic            has_digit_reg, has_digit_next;
    logic [31:0]     count_reg,     count_next;

    // Combinational step for one byte
    always_comb begin
        cbd_pkg::phase_t    ph;
        cbd_pkg::fault_t    flt;
        logic [31:0]        rem;
        logic [31:0]        acc;
        logic               hd;
        logic [31:0]        cnt;
        cbd_pkg::hex_digit_t dig;
        logic [35:0]        acc_wide;
        logic [31:0]        rem_dec;

        // Restart on new_body before the byte is handled
        if (new_body) begin
            ph  = cbd_pkg::PH_SIZE;
            flt = cbd_pkg::FAULT_NONE;
            rem = '0;
            acc = '0;
            hd  = 1'b0;
            cnt = '0;
        end else begin
            ph  = phase_reg;
            flt = fault_reg;
            rem = remaining_reg;
            acc = acc_reg;
            hd  = has_digit_reg;
            cnt = count_reg;
        end

        dig      = cbd_pkg::hex_decode(wire_byte);
        acc_wide = {acc, {cbd_pkg::HEX_SHIFT{1'b0}}} + 36'(dig.value);
        rem_dec  = rem - 32'd1;

        result.data_byte  = 8'd0;
        result.data_valid = 1'b0;
        result.status     = cbd_pkg::ST_BUSY;

        phase_next     = ph;
        fault_next     = flt;
        remaining_next = rem;
        acc_next       = acc;
        has_digit_next = hd;
        count_next     = cnt;

        if (flt == cbd_pkg::FAULT_NONE) begin
            unique case (ph)
                cbd_pkg::PH_SIZE: begin
                    if (dig.is_hex) begin
                        if (acc_wide > {4'd0, max_chunk_size}) begin
                            fault_next = cbd_pkg::FAULT_BIG;
                        end else begin
                            acc_next       = acc_wide[31:0];
                            has_digit_next = 1'b1;
                        end
                    end else if (wire_byte == cbd_pkg::CHAR_SEMI
                                 || wire_byte == cbd_pkg::CHAR_CR) begin
                        if (!hd) begin
                            fault_next = cbd_pkg::FAULT_BAD;
                        end else if (wire_byte == cbd_pkg::CHAR_SEMI) begin
                            phase_next = cbd_pkg::PH_EXT;
                        end else begin
                            phase_next = cbd_pkg::PH_SIZE_LF;
                        end
                    end else begin
                        fault_next = cbd_pkg::FAULT_BAD;
                    end
                end
                cbd_pkg::PH_EXT: begin
                    if (wire_byte == cbd_pkg::CHAR_CR) begin
                        phase_next = cbd_pkg::PH_EXT_LF;
                    end
                end
                cbd_pkg::PH_SIZE_LF, cbd_pkg::PH_EXT_LF: begin
                    if (wire_byte == cbd_pkg::CHAR_LF) begin
                        // Header complete: zero size leads to the last CRLF
                        if (acc == 32'd0) begin
                            phase_next = cbd_pkg::PH_LAST_CR;
                        end else begin
                            remaining_next = acc;
                            phase_next     = cbd_pkg::PH_DATA;
                        end
                        acc_next       = '0;
                        has_digit_next = 1'b0;
                    end else if (ph == cbd_pkg::PH_SIZE_LF) begin
                        fault_next = cbd_pkg::FAULT_BAD;
                    end else if (wire_byte != cbd_pkg::CHAR_CR) begin
                        phase_next = cbd_pkg::PH_EXT;
                    end
                end
                cbd_pkg::PH_DATA: begin
                    if (cnt >= out_capacity) begin
                        fault_next = cbd_pkg::FAULT_BIG;
                    end else begin
                        result.data_byte  = wire_byte;
                        result.data_valid = 1'b1;
                        count_next        = cnt + 32'd1;
                        remaining_next    = rem_dec;
                        if (rem_dec == 32'd0) begin
                            phase_next = cbd_pkg::PH_TRAIL_CR;
                        end
                    end
                end
                cbd_pkg::PH_TRAIL_CR, cbd_pkg::PH_LAST_CR: begin
                    if (wire_byte == cbd_pkg::CHAR_CR) begin
                        phase_next = (ph == cbd_pkg::PH_TRAIL_CR) ? cbd_pkg::PH_TRAIL_LF
                                                                   : cbd_pkg::PH_LAST_LF;
                    end else begin
                        fault_next = cbd_pkg::FAULT_BAD;
                    end
                end
                cbd_pkg::PH_TRAIL_LF: begin
                    if (wire_byte == cbd_pkg::CHAR_LF) begin
                        phase_next = cbd_pkg::PH_SIZE;
                    end else begin
                        fault_next = cbd_pkg::FAULT_BAD;
                    end
                end
                cbd_pkg::PH_LAST_LF: begin
                    if (wire_byte == cbd_pkg::CHAR_LF) begin
                        phase_next    = cbd_pkg::PH_DONE;
                        result.status = cbd_pkg::ST_COMPLETE;
                    end else begin
                        fault_next = cbd_pkg::FAULT_BAD;
                    end
                end
                default: begin
                    phase_next    = cbd_pkg::PH_DONE;
                    result.status = cbd_pkg::ST_BEYOND;
                end
            endcase
        end

        // A fault overrides the result for this and every later byte
        case (fault_next)
            cbd_pkg::FAULT_BAD: begin
                result.status     = cbd_pkg::ST_BAD;
                result.data_byte  = 8'd0;
                result.data_valid = 1'b0;
            end
            cbd_pkg::FAULT_BIG: begin
                result.status     = cbd_pkg::ST_TOO_BIG;
                result.data_byte  = 8'd0;
                result.data_valid = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // Advance the decoder state on each accepted byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= cbd_pkg::PH_SIZE;
            fault_reg     <= cbd_pkg::FAULT_NONE;
            remaining_reg <= '0;
            acc_reg       <= '0;
            has_digit_reg <= 1'b0;
            count_reg     <= '0;
        end else if (step_en) begin
            phase_reg     <= phase_next;
            fault_reg     <= fault_next;
            remaining_reg <= remaining_next;
            acc_reg       <= acc_next;
            has_digit_reg <= has_digit_next;
            count_reg     <= count_next;
        end
    end

endmodule

`default_nettype wire

/* src/chunked_body_decoder.sv */
// ============================================================================
// chunked_body_decoder : HTTP/1.1 chunked transfer body decoder
// An accepted wire byte's result is registered and shows on m_* in the next cycle.
// The input takes one wire byte per cycle while m_tready is high; the output
// register frees itself in the cycle its result is taken, so the stream runs without gaps.
// Reset (aresetn low, synchronous): decoder waits for chunk size digits, no
// fault, counters cleared, output empty, both limits at 1048576.
// ============================================================================
`default_nettype none

module chunked_body_decoder (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Wire byte stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [7:0]                     s_tdata,   // [7:0] wire_byte
    input  wire logic                           s_tuser,   // [0] new_body
    // Decoded stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [7:0]                          m_tdata,   // [7:0] data_byte
    output logic [3:0]                          m_tuser,   // [0] data_valid, [3:1] status
    // Register port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [cbd_pkg::REG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    logic [31:0]      max_chunk_reg;
    logic [31:0]      out_cap_reg;
    logic             reg_write;
    logic             in_accept;
    cbd_pkg::result_t result;
    logic             m_tvalid_reg;
    logic [7:0]       m_tdata_reg;
    logic [3:0]       m_tuser_reg;

    // Register port: always ready, word picked by paddr[2]
    assign pready    = 1'b1;
    assign reg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == cbd_pkg::REG_OUT_CAPACITY) ? out_cap_reg : max_chunk_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_chunk_reg <= cbd_pkg::MAX_CHUNK_RESET;
            out_cap_reg   <= cbd_pkg::OUT_CAP_RESET;
        end else if (reg_write) begin
            if (paddr[2] == cbd_pkg::REG_MAX_CHUNK) begin
                max_chunk_reg <= pwdata;
            end else begin
                out_cap_reg <= pwdata;
            end
        end
    end

    // Take a byte whenever the output register is empty or being drained
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    cbd_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step_en        (in_accept),
        .wire_byte      (s_tdata),
        .new_body       (s_tuser),
        .max_chunk_size (max_chunk_reg),
        .out_capacity   (out_cap_reg),
        .result         (result)
    );

    // Hold the result until the downstream side takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (in_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            m_tdata_reg <= result.data_byte;
            m_tuser_reg <= {result.status, result.data_valid};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire
